// ===== rtl/core/cls_pkg.sv =====
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types, field widths and the LQI adjustment table for the
// per-channel link statistics block.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int CLS_CHANNELS   = 16;
  localparam int CLS_COUNT_BITS = 16;

  localparam int MODE_W    = 2;
  localparam int CHAN_W    = 4;
  localparam int SMP_W     = 8;   // rssi, lqi and the averages
  localparam int OCNT_W    = 16;  // count fields of the result word
  localparam int SUM_W     = 24;  // stored sums and the total fields

  typedef enum logic [MODE_W-1:0] {
    MODE_TX   = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_READ = 2'd2
  } cls_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV
  } cls_state_e;

  // Adjusted LQI: ((255 * lqi + 10) / 20) - 1135, kept modulo 256.
  function automatic logic [255:0][SMP_W-1:0] lqi_lut_build();
    logic [255:0][SMP_W-1:0] lut;
    int s;
    for (int i = 0; i < 256; i++) begin
      s      = (255 * i + 10) / 20 - 1135;
      lut[i] = SMP_W'(s);
    end
    return lut;
  endfunction

  localparam logic [255:0][SMP_W-1:0] LqiLut = lqi_lut_build();

endpackage

// ===== rtl/core/cls_in_if.sv =====
// ----------------------------------------------------------------------------
// cls_in_if
// Event channel: mode, channel index, RSSI and raw LQI of one event word.
// ----------------------------------------------------------------------------
interface cls_in_if import cls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [CHAN_W-1:0]        channel;
  logic signed [SMP_W-1:0]  rssi;
  logic [SMP_W-1:0]         lqi;

  modport source (output valid, mode, channel, rssi, lqi, input ready);
  modport sink   (input valid, mode, channel, rssi, lqi, output ready);
endinterface

// ===== rtl/core/cls_out_if.sv =====
// ----------------------------------------------------------------------------
// cls_out_if
// Report channel: one channel record with its rounded averages per word.
// ----------------------------------------------------------------------------
interface cls_out_if import cls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OCNT_W-1:0]        tx_count;
  logic [OCNT_W-1:0]        ack_count;
  logic [OCNT_W-1:0]        sample_count;
  logic signed [SUM_W-1:0]  rssi_total;
  logic [SUM_W-1:0]         lqi_total;
  logic signed [SMP_W-1:0]  rssi_avg;
  logic [SMP_W-1:0]         lqi_avg;

  modport source (output valid, tx_count, ack_count, sample_count, rssi_total,
                  lqi_total, rssi_avg, lqi_avg, input ready);
  modport sink   (input valid, tx_count, ack_count, sample_count, rssi_total,
                  lqi_total, rssi_avg, lqi_avg, output ready);
endinterface

// ===== rtl/core/channel_link_stats.sv =====
// ----------------------------------------------------------------------------
// channel_link_stats
// Per-channel radio link statistics: transmit, acknowledgement and sample
// counts plus RSSI and LQI sums, reported with rounded averages on read.
// ----------------------------------------------------------------------------
//
//   port    dir  word                                   accepted when
//   in_i    in   mode, channel, rssi, lqi               valid && ready
//   out_o   out  counts, totals, rssi_avg, lqi_avg       valid && ready
//
// Sequence: a transmit or acknowledgement word is a record read at accept,
// then a modify and write back of the single record memory. A read word also
// starts the two bit-serial dividers that form the RSSI and LQI averages in
// parallel; its report word is loaded once both dividers are done and the
// report register is free.
// Reset: per-entry valid bits clear at once; an entry not yet written reads
// as an all-zero record, so there is no clearing pass.
// Stalls: the report register decouples the sides; a new event is taken while
// a report waits, and a finished division holds until the report is free.
// ----------------------------------------------------------------------------
module channel_link_stats import cls_pkg::*; #(
  parameter int CHANNELS   = CLS_CHANNELS,
  parameter int COUNT_BITS = CLS_COUNT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cls_in_if.sink    in_i,
  cls_out_if.source out_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CB    = COUNT_BITS;
  localparam int REC_W = 3 * CB + 2 * SUM_W;
  // division operand width: room for a sum or a half count plus sign
  localparam int DIV_W = ((CB > SUM_W) ? CB : SUM_W) + 2;

  // Record layout in the memory word
  localparam int TX_LO  = 0;
  localparam int ACK_LO = CB;
  localparam int N_LO   = 2 * CB;
  localparam int RS_LO  = 3 * CB;
  localparam int LS_LO  = 3 * CB + SUM_W;

  // --------------------------------------------------------------------------
  // Accepted event word
  // --------------------------------------------------------------------------
  cls_state_e              state_q, state_d;
  logic [MODE_W-1:0]       mode_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    ch_ok_q;
  logic signed [SMP_W-1:0] rssi_q;
  logic [SMP_W-1:0]        lqi_q;

  logic                    in_acc;
  logic [IDX_W-1:0]        in_idx;

  assign in_idx = IDX_W'(in_i.channel);
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_ok_q <= 1'b0;
    end else if (in_acc) begin
      ch_ok_q <= (32'(in_i.channel) < CHANNELS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      idx_q  <= in_idx;
      rssi_q <= in_i.rssi;
      lqi_q  <= in_i.lqi;
    end
  end

  // --------------------------------------------------------------------------
  // Record memory: read at accept, write back in the modify cycle
  // --------------------------------------------------------------------------
  logic [REC_W-1:0]    rec_mem [CHANNELS];
  logic [REC_W-1:0]    rd_q;
  logic [CHANNELS-1:0] vld_q;
  logic                rd_vld_q;
  logic                mem_we;
  logic [REC_W-1:0]    wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[idx_q] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= rec_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= vld_q[in_idx];
      end
    end
  end

  // An entry never written reads as the all-zero reset record
  logic [REC_W-1:0]        rec;
  logic [CB-1:0]           rec_tx, rec_ack, rec_n;
  logic signed [SUM_W-1:0] rec_rs;
  logic [SUM_W-1:0]        rec_ls;

  assign rec     = rd_vld_q ? rd_q : '0;
  assign rec_tx  = rec[TX_LO  +: CB];
  assign rec_ack = rec[ACK_LO +: CB];
  assign rec_n   = rec[N_LO   +: CB];
  assign rec_rs  = rec[RS_LO  +: SUM_W];
  assign rec_ls  = rec[LS_LO  +: SUM_W];

  // --------------------------------------------------------------------------
  // Update arithmetic
  // --------------------------------------------------------------------------
  logic [CB-1:0]           tx_inc, ack_inc, n_inc;
  logic                    n_sat;
  logic [SUM_W-1:0]        rs_new, ls_new;
  logic signed [DIV_W-1:0] half, r_num, l_num, r_mag;
  logic                    r_neg;

  always_comb begin
    tx_inc  = rec_tx + 1'b1;
    ack_inc = rec_ack + 1'b1;
    n_inc   = rec_n + 1'b1;
    n_sat   = &rec_n;
    rs_new  = rec_rs + SUM_W'(rssi_q);
    ls_new  = rec_ls + SUM_W'(LqiLut[lqi_q]);
    // rounding offsets: rssi rounds away from the positive side, lqi up
    half    = DIV_W'(rec_n >> 1);
    r_num   = DIV_W'(rec_rs) - half;
    l_num   = DIV_W'(rec_ls) + half;
    r_neg   = r_num[DIV_W-1];
    r_mag   = r_neg ? -r_num : r_num;
  end

  // --------------------------------------------------------------------------
  // Average dividers
  // --------------------------------------------------------------------------
  logic             div_start;
  logic             r_busy, l_busy;
  logic [DIV_W-1:0] r_quot, l_quot;

  cls_div #(.NUM_W(DIV_W), .DEN_W(CB)) u_rssi_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (r_mag),
    .den_i   (rec_n),
    .busy_o  (r_busy),
    .quot_o  (r_quot)
  );

  cls_div #(.NUM_W(DIV_W), .DEN_W(CB)) u_lqi_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (l_num),
    .den_i   (rec_n),
    .busy_o  (l_busy),
    .quot_o  (l_quot)
  );

  // Record snapshot held while the dividers run
  logic [CB-1:0]           h_tx_q, h_ack_q, h_n_q;
  logic signed [SUM_W-1:0] h_rs_q;
  logic [SUM_W-1:0]        h_ls_q;
  logic                    h_neg_q;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      h_tx_q  <= rec_tx;
      h_ack_q <= rec_ack;
      h_n_q   <= rec_n;
      h_rs_q  <= rec_rs;
      h_ls_q  <= rec_ls;
      h_neg_q <= r_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    wr_data    = rec;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        state_d = ST_IDLE;
        if (ch_ok_q) begin
          unique case (mode_q)
            MODE_TX: begin
              mem_we                = 1'b1;
              wr_data[TX_LO +: CB]  = tx_inc;
            end
            MODE_ACK: begin
              mem_we                = 1'b1;
              wr_data[ACK_LO +: CB] = ack_inc;
              // hold the sums once the sample count is pinned
              if (!n_sat) begin
                wr_data[N_LO  +: CB]    = n_inc;
                wr_data[RS_LO +: SUM_W] = rs_new;
                wr_data[LS_LO +: SUM_W] = ls_new;
              end
            end
            MODE_READ: begin
              mem_we                  = 1'b1;
              wr_data[N_LO  +: CB]    = '0;
              wr_data[RS_LO +: SUM_W] = '0;
              wr_data[LS_LO +: SUM_W] = '0;
              div_start               = 1'b1;
              state_d                 = ST_DIV;
            end
            default: begin
              // drop the unused mode code
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!r_busy && !l_busy && out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Report register
  // --------------------------------------------------------------------------
  logic [SMP_W-1:0] r_avg, l_avg;

  always_comb begin
    r_avg = h_neg_q ? SMP_W'(-r_quot) : r_quot[SMP_W-1:0];
    l_avg = l_quot[SMP_W-1:0];
    if (h_n_q == '0) begin
      r_avg = '0;
      l_avg = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.tx_count     <= OCNT_W'(h_tx_q);
      out_o.ack_count    <= OCNT_W'(h_ack_q);
      out_o.sample_count <= OCNT_W'(h_n_q);
      out_o.rssi_total   <= h_rs_q;
      out_o.lqi_total    <= h_ls_q;
      out_o.rssi_avg     <= r_avg;
      out_o.lqi_avg      <= l_avg;
    end
  end

  assign out_o.valid = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_busy || l_busy) |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide state");

  a_report_from_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DIV))
    else $error("report raised without a finished division");

  a_read_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && ch_ok_q && mode_q == MODE_READ) |=> (state_q == ST_DIV))
    else $error("read word did not start the dividers");

  a_dividers_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_busy == l_busy)
    else $error("average dividers out of step");

endmodule

// ===== rtl/core/cls_div.sv =====
// ----------------------------------------------------------------------------
// cls_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cls_div import cls_pkg::*; #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      // shift the next dividend bit in, retire one quotient bit
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule
